>>> hdl/ywpid_pkg.sv
package ywpid_pkg;

  // datapath word format
  localparam int unsigned DATA_WIDTH = 32;
  localparam int unsigned FRAC_BITS  = 16;
  localparam int unsigned THR_FRAC   = 14;
  localparam int unsigned THR_WIDTH  = 16;
  localparam int unsigned OUT_WIDTH  = 32;
  localparam int unsigned GAIN_WIDTH = 31;
  localparam int unsigned STEP_WIDTH = 17;
  localparam int unsigned ADDR_WIDTH = 5;
  localparam int unsigned PDATA_WIDTH = 32;

  // register map, word index
  typedef enum logic [2:0] {
    REG_KP        = 3'd0,
    REG_KI        = 3'd1,
    REG_KD        = 3'd2,
    REG_STEP      = 3'd3,
    REG_INT_LIMIT = 3'd4,
    REG_MAX_MZ    = 3'd5,
    REG_MAX_DRIVE = 3'd6,
    REG_MAX_BRAKE = 3'd7
  } reg_addr_e;

  localparam logic [STEP_WIDTH-1:0] STEP_TIME_RST = 17'd655;

  typedef struct packed {
    logic [GAIN_WIDTH-1:0] kp_gain;
    logic [GAIN_WIDTH-1:0] ki_gain;
    logic [GAIN_WIDTH-1:0] kd_rate_gain;
    logic [STEP_WIDTH-1:0] step_time;
    logic [GAIN_WIDTH-1:0] int_limit;
    logic [GAIN_WIDTH-1:0] mz_limit;
    logic [GAIN_WIDTH-1:0] drive_limit;
    logic [GAIN_WIDTH-1:0] brake_limit;
  } cfg_t;

  // product selected on the shared multiplier
  typedef enum logic [2:0] {
    OP_INTEG    = 3'd0,
    OP_PROP     = 3'd1,
    OP_DERIV    = 3'd2,
    OP_INTGAIN  = 3'd3,
    OP_THROTTLE = 3'd4
  } op_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ERR,
    S_DIFF,
    S_MUL,
    S_RND,
    S_INTUPD,
    S_SUM,
    S_MZ,
    S_CLAMP,
    S_OUT
  } state_e;

  typedef struct packed {
    logic load_in;
    logic calc_err;
    logic calc_diff;
    logic mul_go;
    logic rnd_wr;
    logic int_upd;
    logic sum_pi;
    logic sum_mz;
    logic clamp_mz;
    logic out_load;
    op_e  op;
  } cmd_t;

endpackage

>>> hdl/ywpid_regs.sv
module ywpid_regs (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [ywpid_pkg::ADDR_WIDTH-1:0]    paddr,
  input  logic [ywpid_pkg::PDATA_WIDTH-1:0]   pwdata,
  output logic [ywpid_pkg::PDATA_WIDTH-1:0]   prdata,
  output logic                                pready,
  output ywpid_pkg::cfg_t                     cfg_o
);
  import ywpid_pkg::*;

  cfg_t      cfg_q;
  reg_addr_e waddr;
  logic      wr_en;

  assign pready = 1'b1;
  assign waddr  = reg_addr_e'(paddr[ADDR_WIDTH-1:2]);
  assign wr_en  = psel && penable && pwrite;

  // register writes on the access cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{step_time: STEP_TIME_RST, default: '0};
    end else if (wr_en) begin
      unique case (waddr)
        REG_KP:        cfg_q.kp_gain      <= pwdata[GAIN_WIDTH-1:0];
        REG_KI:        cfg_q.ki_gain      <= pwdata[GAIN_WIDTH-1:0];
        REG_KD:        cfg_q.kd_rate_gain <= pwdata[GAIN_WIDTH-1:0];
        REG_STEP:      cfg_q.step_time    <= pwdata[STEP_WIDTH-1:0];
        REG_INT_LIMIT: cfg_q.int_limit    <= pwdata[GAIN_WIDTH-1:0];
        REG_MAX_MZ:    cfg_q.mz_limit     <= pwdata[GAIN_WIDTH-1:0];
        REG_MAX_DRIVE: cfg_q.drive_limit  <= pwdata[GAIN_WIDTH-1:0];
        REG_MAX_BRAKE: cfg_q.brake_limit  <= pwdata[GAIN_WIDTH-1:0];
      endcase
    end
  end

  // read mux
  always_comb begin
    unique case (waddr)
      REG_KP:        prdata = PDATA_WIDTH'(cfg_q.kp_gain);
      REG_KI:        prdata = PDATA_WIDTH'(cfg_q.ki_gain);
      REG_KD:        prdata = PDATA_WIDTH'(cfg_q.kd_rate_gain);
      REG_STEP:      prdata = PDATA_WIDTH'(cfg_q.step_time);
      REG_INT_LIMIT: prdata = PDATA_WIDTH'(cfg_q.int_limit);
      REG_MAX_MZ:    prdata = PDATA_WIDTH'(cfg_q.mz_limit);
      REG_MAX_DRIVE: prdata = PDATA_WIDTH'(cfg_q.drive_limit);
      REG_MAX_BRAKE: prdata = PDATA_WIDTH'(cfg_q.brake_limit);
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

>>> hdl/ywpid_ctrl.sv
module ywpid_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output ywpid_pkg::cmd_t cmd_o
);
  import ywpid_pkg::*;

  state_e state_q, state_d;
  op_e    op_q, op_d;
  logic   out_valid_q, out_valid_d;
  cmd_t   cmd;

  // state, op and output valid registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      op_q        <= OP_INTEG;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      op_q        <= op_d;
      out_valid_q <= out_valid_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d    = state_q;
    op_d       = op_q;
    cmd        = '0;
    cmd.op     = op_q;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd.load_in = 1'b1;
          state_d     = S_ERR;
        end
      end
      S_ERR: begin
        cmd.calc_err = 1'b1;
        state_d      = S_DIFF;
      end
      S_DIFF: begin
        cmd.calc_diff = 1'b1;
        op_d          = OP_INTEG;
        state_d       = S_MUL;
      end
      S_MUL: begin
        cmd.mul_go = 1'b1;
        state_d    = S_RND;
      end
      S_RND: begin
        cmd.rnd_wr = 1'b1;
        state_d    = S_MUL;
        case (op_q)
          OP_INTEG:    state_d = S_INTUPD;
          OP_PROP:     op_d = OP_DERIV;
          OP_DERIV:    op_d = OP_INTGAIN;
          OP_INTGAIN:  op_d = OP_THROTTLE;
          OP_THROTTLE: state_d = S_SUM;
          default:     state_d = S_SUM;
        endcase
      end
      S_INTUPD: begin
        cmd.int_upd = 1'b1;
        op_d        = OP_PROP;
        state_d     = S_MUL;
      end
      S_SUM: begin
        cmd.sum_pi = 1'b1;
        state_d    = S_MZ;
      end
      S_MZ: begin
        cmd.sum_mz = 1'b1;
        state_d    = S_CLAMP;
      end
      S_CLAMP: begin
        cmd.clamp_mz = 1'b1;
        state_d      = S_OUT;
      end
      S_OUT: begin
        // wait until the output register is free
        if (!out_valid_q || out_ready_i) begin
          cmd.out_load = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // output valid tracks the result register
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign cmd_o       = cmd;

  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> state_q == S_ERR)
    else $error("accepted item did not start the error step");

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |-> (!out_valid_q || out_ready_i))
    else $error("result loaded over an untaken result");

  a_rnd_after_mul: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_RND |-> $past(state_q) == S_MUL)
    else $error("rounding step without a multiply");

  a_last_op: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_RND && op_q == OP_THROTTLE |=> state_q == S_SUM)
    else $error("torque product did not close the multiply sequence");

endmodule

>>> hdl/ywpid_datapath.sv
module ywpid_datapath (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  ywpid_pkg::cmd_t                       cmd_i,
  input  ywpid_pkg::cfg_t                       cfg_i,
  input  logic signed [31:0]                    yaw_rate_ref_i,
  input  logic signed [31:0]                    yaw_rate_meas_i,
  input  logic signed [ywpid_pkg::THR_WIDTH-1:0] throttle_i,
  output logic signed [ywpid_pkg::OUT_WIDTH-1:0] mz_req_o,
  output logic signed [ywpid_pkg::OUT_WIDTH-1:0] torque_req_o
);
  import ywpid_pkg::*;

  localparam int unsigned DW = DATA_WIDTH;
  localparam int unsigned PW = DATA_WIDTH + GAIN_WIDTH;
  localparam logic signed [DW-1:0] SMAX = {1'b0, {(DW-1){1'b1}}};
  localparam logic signed [DW-1:0] SMIN = {1'b1, {(DW-1){1'b0}}};
  localparam logic [PW:0] POS_MAG = {{(PW-DW+2){1'b0}}, {(DW-1){1'b1}}};
  localparam logic [PW:0] NEG_MAG = POS_MAG + 1'b1;
  localparam logic [PW:0] HALF_F  = {{PW{1'b0}}, 1'b1} << (FRAC_BITS-1);
  localparam logic [PW:0] HALF_T  = {{PW{1'b0}}, 1'b1} << (THR_FRAC-1);

  function automatic logic signed [DW-1:0] sat_add(input logic signed [DW-1:0] a,
                                                   input logic signed [DW-1:0] b);
    logic signed [DW:0] s;
    s = {a[DW-1], a} + {b[DW-1], b};
    if (s[DW] != s[DW-1]) begin
      sat_add = s[DW] ? SMIN : SMAX;
    end else begin
      sat_add = s[DW-1:0];
    end
  endfunction

  function automatic logic signed [DW-1:0] sat_sub(input logic signed [DW-1:0] a,
                                                   input logic signed [DW-1:0] b);
    logic signed [DW:0] s;
    s = {a[DW-1], a} - {b[DW-1], b};
    if (s[DW] != s[DW-1]) begin
      sat_sub = s[DW] ? SMIN : SMAX;
    end else begin
      sat_sub = s[DW-1:0];
    end
  endfunction

  function automatic logic signed [DW-1:0] clamp_sym(input logic signed [DW-1:0] v,
                                                     input logic [GAIN_WIDTH-1:0] lim);
    logic signed [DW-1:0] l;
    l = $signed({{(DW-GAIN_WIDTH){1'b0}}, lim});
    if (v > l) begin
      clamp_sym = l;
    end else if (v < -l) begin
      clamp_sym = -l;
    end else begin
      clamp_sym = v;
    end
  endfunction

  logic signed [DW-1:0] ref_q, meas_q, thr_q;
  logic signed [DW-1:0] err_q, diff_q, last_q, integ_q;
  logic signed [DW-1:0] est_q, p_q, i_q, d_q, tq_q, pi_q, mz_q;
  logic signed [OUT_WIDTH-1:0] mz_out_q, tq_out_q;
  logic [PW-1:0]         prod_q;
  logic                  neg_q;

  logic signed [DW-1:0]  op_a;
  logic [GAIN_WIDTH-1:0] op_b;
  logic [DW-1:0]         mag;
  logic [PW:0]           rsum, mval;
  logic signed [DW-1:0]  rnd;
  logic signed [DW-1:0]  tq_upper, tq_lower, tq_clamped;

  // operand select for the shared multiplier
  always_comb begin
    case (cmd_i.op)
      OP_INTEG: begin
        op_a = err_q;
        op_b = GAIN_WIDTH'(cfg_i.step_time);
      end
      OP_PROP: begin
        op_a = err_q;
        op_b = cfg_i.kp_gain;
      end
      OP_DERIV: begin
        op_a = diff_q;
        op_b = cfg_i.kd_rate_gain;
      end
      OP_INTGAIN: begin
        op_a = integ_q;
        op_b = cfg_i.ki_gain;
      end
      OP_THROTTLE: begin
        op_a = thr_q;
        op_b = cfg_i.drive_limit;
      end
      default: begin
        op_a = thr_q;
        op_b = cfg_i.drive_limit;
      end
    endcase
    mag = op_a[DW-1] ? (~op_a + 1'b1) : op_a;
  end

  // round to nearest away from zero, restore sign, saturate
  always_comb begin
    if (cmd_i.op == OP_THROTTLE) begin
      rsum = {1'b0, prod_q} + HALF_T;
      mval = rsum >> THR_FRAC;
    end else begin
      rsum = {1'b0, prod_q} + HALF_F;
      mval = rsum >> FRAC_BITS;
    end
    if (neg_q) begin
      rnd = (mval > NEG_MAG) ? SMIN : -$signed(mval[DW-1:0]);
    end else begin
      rnd = (mval > POS_MAG) ? SMAX : $signed(mval[DW-1:0]);
    end
  end

  // torque window
  always_comb begin
    tq_upper = $signed({{(DW-GAIN_WIDTH){1'b0}}, cfg_i.drive_limit});
    tq_lower = -$signed({{(DW-GAIN_WIDTH){1'b0}}, cfg_i.brake_limit});
    if (tq_q > tq_upper) begin
      tq_clamped = tq_upper;
    end else if (tq_q < tq_lower) begin
      tq_clamped = tq_lower;
    end else begin
      tq_clamped = tq_q;
    end
  end

  // controller state kept across items
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q  <= '0;
      integ_q <= '0;
    end else begin
      if (cmd_i.calc_diff) begin
        last_q <= err_q;
      end
      if (cmd_i.int_upd) begin
        integ_q <= clamp_sym(sat_add(integ_q, est_q), cfg_i.int_limit);
      end
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      ref_q  <= yaw_rate_ref_i;
      meas_q <= yaw_rate_meas_i;
      thr_q  <= {{(DW-THR_WIDTH){throttle_i[THR_WIDTH-1]}}, throttle_i};
    end
    if (cmd_i.calc_err) begin
      err_q <= sat_sub(ref_q, meas_q);
    end
    if (cmd_i.calc_diff) begin
      diff_q <= sat_sub(err_q, last_q);
    end
    if (cmd_i.mul_go) begin
      prod_q <= mag * op_b;
      neg_q  <= op_a[DW-1];
    end
    if (cmd_i.rnd_wr) begin
      case (cmd_i.op)
        OP_INTEG:    est_q <= rnd;
        OP_PROP:     p_q   <= rnd;
        OP_DERIV:    d_q   <= rnd;
        OP_INTGAIN:  i_q   <= rnd;
        OP_THROTTLE: tq_q  <= rnd;
        default:     tq_q  <= rnd;
      endcase
    end
    if (cmd_i.sum_pi) begin
      pi_q <= sat_add(p_q, i_q);
    end
    if (cmd_i.sum_mz) begin
      mz_q <= sat_add(pi_q, d_q);
      tq_q <= tq_clamped;
    end
    if (cmd_i.clamp_mz) begin
      mz_q <= clamp_sym(mz_q, cfg_i.mz_limit);
    end
    if (cmd_i.out_load) begin
      mz_out_q <= OUT_WIDTH'(mz_q);
      tq_out_q <= OUT_WIDTH'(tq_q);
    end
  end

  assign mz_req_o     = mz_out_q;
  assign torque_req_o = tq_out_q;

endmodule

>>> hdl/yaw_rate_pid_torque_controller.sv
// channel  | signals                                               | direction
// ---------+-------------------------------------------------------+----------
// in       | in_valid_i, in_ready_o, yaw_rate_ref_i,               | to block
//          | yaw_rate_meas_i, throttle_i                           |
// out      | out_valid_o, out_ready_i, mz_req_o, torque_req_o      | from block
// cfg      | psel, penable, pwrite, paddr, pwdata, prdata, pready  | both
//
// one item runs from accept to result valid through error and difference,
// five products through one shared 32x31 multiplier (each a multiply then
// a round), one integral update, and sums, clamps and result load. the
// next item is taken the cycle after the result is loaded, so the block
// works on one item at a time.
// reset clears the integral, the last error and all handshake state.
// a stalled result holds in the output register while the next item runs;
// that item waits at its last step until the result is taken.
module yaw_rate_pid_torque_controller (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic signed [31:0]                    yaw_rate_ref_i,
  input  logic signed [31:0]                    yaw_rate_meas_i,
  input  logic signed [ywpid_pkg::THR_WIDTH-1:0] throttle_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic signed [ywpid_pkg::OUT_WIDTH-1:0] mz_req_o,
  output logic signed [ywpid_pkg::OUT_WIDTH-1:0] torque_req_o,
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [ywpid_pkg::ADDR_WIDTH-1:0]      paddr,
  input  logic [ywpid_pkg::PDATA_WIDTH-1:0]     pwdata,
  output logic [ywpid_pkg::PDATA_WIDTH-1:0]     prdata,
  output logic                                  pready
);
  import ywpid_pkg::*;

  cfg_t cfg;
  cmd_t cmd;

  // configuration registers
  ywpid_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // sequencer
  ywpid_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd)
  );

  // arithmetic
  ywpid_datapath u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .cfg_i           (cfg),
    .yaw_rate_ref_i  (yaw_rate_ref_i),
    .yaw_rate_meas_i (yaw_rate_meas_i),
    .throttle_i      (throttle_i),
    .mz_req_o        (mz_req_o),
    .torque_req_o    (torque_req_o)
  );

endmodule

>>> tb/sv/yaw_rate_pid_torque_controller_tb.sv
`timescale 1ns / 1ps

module yaw_rate_pid_torque_controller_tb;
  import ywpid_pkg::*;

  typedef longint unsigned u64_t;

  typedef struct {
    logic signed [31:0]          rate_cmd;
    logic signed [31:0]          rate_meas;
    logic signed [THR_WIDTH-1:0] throttle;
  } rate_item_t;

  typedef struct {
    logic signed [OUT_WIDTH-1:0] mz_req;
    logic signed [OUT_WIDTH-1:0] torque_req;
  } ctrl_out_t;

  localparam longint WORD_MAX  = 64'sd2147483647;
  localparam longint WORD_MIN  = -64'sd2147483648;
  localparam int     STALL_AT  = 60;
  localparam int     STALL_LEN = 300;

  // clock and reset
  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  // block inputs, known from time zero
  logic                        in_valid_i      = 1'b0;
  logic signed [31:0]          yaw_rate_ref_i  = '0;
  logic signed [31:0]          yaw_rate_meas_i = '0;
  logic signed [THR_WIDTH-1:0] throttle_i      = '0;
  logic                        out_ready_i     = 1'b0;
  logic                        psel            = 1'b0;
  logic                        penable         = 1'b0;
  logic                        pwrite          = 1'b0;
  logic [ADDR_WIDTH-1:0]       paddr           = '0;
  logic [PDATA_WIDTH-1:0]      pwdata          = '0;

  // block outputs
  logic                        in_ready_o;
  logic                        out_valid_o;
  logic signed [OUT_WIDTH-1:0] mz_req_o;
  logic signed [OUT_WIDTH-1:0] torque_req_o;
  logic [PDATA_WIDTH-1:0]      prdata;
  logic                        pready;

  // register copies and controller state
  u64_t   reg_shadow [8];
  longint integ_acc = 0;
  longint prev_err  = 0;

  rate_item_t pending_q [$];
  ctrl_out_t  expected_q [$];

  int          error_count = 0;
  int          in_count;
  int unsigned in_gap;
  int unsigned out_hold;
  int unsigned stall_left;
  logic        stall_done;
  logic        no_idle = 1'b0;

  yaw_rate_pid_torque_controller u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .yaw_rate_ref_i  (yaw_rate_ref_i),
    .yaw_rate_meas_i (yaw_rate_meas_i),
    .throttle_i      (throttle_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .mz_req_o        (mz_req_o),
    .torque_req_o    (torque_req_o),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  // 100 MHz clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // saturate to the signed word range
  function automatic longint sat_word(input longint v);
    return (v > WORD_MAX) ? WORD_MAX : ((v < WORD_MIN) ? WORD_MIN : v);
  endfunction

  function automatic longint clamp_sym(input longint v, input u64_t lim);
    longint l;
    l = longint'(lim);
    return (v > l) ? l : ((v < -l) ? -l : v);
  endfunction

  // signed times unsigned fixed point, rounded half away from zero
  function automatic longint scale_mul(input longint a, input u64_t b, input int unsigned sh);
    u64_t mag;
    u64_t m;
    if (a < 0) mag = -a;
    else mag = a;
    m = (mag * b + (u64_t'(1) << (sh - 1))) >> sh;
    if (a < 0) return (m > 64'h8000_0000) ? WORD_MIN : -longint'(m);
    return (m > 64'h7fff_ffff) ? WORD_MAX : longint'(m);
  endfunction

  // one control update: integral, derivative, moment and torque
  function automatic ctrl_out_t step_controller(input logic signed [31:0] rate_cmd,
                                                input logic signed [31:0] rate_meas,
                                                input logic signed [THR_WIDTH-1:0] thr);
    ctrl_out_t res;
    longint    err;
    longint    diff;
    longint    mz;
    longint    tq;
    err       = sat_word(longint'(rate_cmd) - longint'(rate_meas));
    integ_acc = sat_word(integ_acc + scale_mul(err, reg_shadow[REG_STEP], FRAC_BITS));
    integ_acc = clamp_sym(integ_acc, reg_shadow[REG_INT_LIMIT]);
    diff      = sat_word(err - prev_err);
    prev_err  = err;
    mz = sat_word(scale_mul(err, reg_shadow[REG_KP], FRAC_BITS)
                  + scale_mul(integ_acc, reg_shadow[REG_KI], FRAC_BITS));
    mz = sat_word(mz + scale_mul(diff, reg_shadow[REG_KD], FRAC_BITS));
    mz = clamp_sym(mz, reg_shadow[REG_MAX_MZ]);
    tq = scale_mul(longint'(thr), reg_shadow[REG_MAX_DRIVE], THR_FRAC);
    if (tq > longint'(reg_shadow[REG_MAX_DRIVE])) tq = longint'(reg_shadow[REG_MAX_DRIVE]);
    if (tq < -longint'(reg_shadow[REG_MAX_BRAKE])) tq = -longint'(reg_shadow[REG_MAX_BRAKE]);
    tq = sat_word(tq);
    res.mz_req     = mz[31:0];
    res.torque_req = tq[31:0];
    return res;
  endfunction

  task automatic report_error(input string msg);
    if (error_count < 200) $display("ERROR %0t ns: %s", $time, msg);
    error_count++;
  endtask

  // input driver, one transaction per pending item
  always @(posedge clk_i or negedge rst_ni) begin : in_driver
    int unsigned gap;
    rate_item_t  nxt;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_gap     <= 0;
      in_count   <= 0;
    end else begin
      gap = in_gap;
      if (in_valid_i && in_ready_o) begin
        expected_q.push_back(step_controller(yaw_rate_ref_i, yaw_rate_meas_i, throttle_i));
        in_count <= in_count + 1;
        gap = no_idle ? 0 : $urandom_range(0, 3);
      end
      if (!in_valid_i || in_ready_o) begin
        if (gap != 0) begin
          in_valid_i <= 1'b0;
          in_gap     <= gap - 1;
        end else if (pending_q.size() != 0) begin
          nxt = pending_q.pop_front();
          yaw_rate_ref_i  <= nxt.rate_cmd;
          yaw_rate_meas_i <= nxt.rate_meas;
          throttle_i      <= nxt.throttle;
          in_valid_i      <= 1'b1;
          in_gap          <= 0;
        end else begin
          in_valid_i <= 1'b0;
          in_gap     <= 0;
        end
      end
    end
  end

  // one long receiver hold-off so the block backs up into its input
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stall_left <= 0;
      stall_done <= 1'b0;
    end else if (!stall_done && in_count == STALL_AT) begin
      stall_left <= STALL_LEN;
      stall_done <= 1'b1;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end
  end

  // output monitor and checker
  always @(posedge clk_i or negedge rst_ni) begin : out_monitor
    int unsigned hold;
    ctrl_out_t   want;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      out_hold    <= 0;
    end else begin
      hold = out_hold;
      if (out_valid_o && out_ready_i) begin
        if (expected_q.size() == 0) begin
          report_error($sformatf("result with nothing expected: moment %0d torque %0d",
                                 mz_req_o, torque_req_o));
        end else begin
          want = expected_q.pop_front();
          if (mz_req_o !== want.mz_req)
            report_error($sformatf("mz_req got %0d expected %0d",
                                   mz_req_o, want.mz_req));
          if (torque_req_o !== want.torque_req)
            report_error($sformatf("torque_req got %0d expected %0d",
                                   torque_req_o, want.torque_req));
        end
        hold = no_idle ? 0 : $urandom_range(0, 3);
      end
      if (stall_left != 0) begin
        out_ready_i <= 1'b0;
        out_hold    <= hold;
      end else if (hold != 0) begin
        out_ready_i <= 1'b0;
        out_hold    <= hold - 1;
      end else begin
        out_ready_i <= 1'b1;
        out_hold    <= 0;
      end
    end
  end

  // apb write: setup then access, register taken on the access edge
  task automatic write_reg(input reg_addr_e idx, input logic [31:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    reg_shadow[idx] = (idx == REG_STEP) ? u64_t'(value[STEP_WIDTH-1:0])
                                        : u64_t'(value[GAIN_WIDTH-1:0]);
  endtask

  task automatic write_all(input logic [31:0] kp, input logic [31:0] ki, input logic [31:0] kd,
                           input logic [31:0] step, input logic [31:0] ilim,
                           input logic [31:0] mz, input logic [31:0] drv,
                           input logic [31:0] brk);
    write_reg(REG_KP, kp);
    write_reg(REG_KI, ki);
    write_reg(REG_KD, kd);
    write_reg(REG_STEP, step);
    write_reg(REG_INT_LIMIT, ilim);
    write_reg(REG_MAX_MZ, mz);
    write_reg(REG_MAX_DRIVE, drv);
    write_reg(REG_MAX_BRAKE, brk);
  endtask

  task automatic add_item(input logic signed [31:0] rate_cmd, input logic signed [31:0] rate_meas,
                          input logic signed [THR_WIDTH-1:0] thr);
    rate_item_t it;
    it.rate_cmd  = rate_cmd;
    it.rate_meas = rate_meas;
    it.throttle  = thr;
    pending_q.push_back(it);
  endtask

  // wait until every item is taken and every result has come back
  task automatic wait_idle();
    do @(negedge clk_i);
    while (pending_q.size() != 0 || in_valid_i || expected_q.size() != 0);
  endtask

  // mostly realistic rates, some full range and some extremes
  function automatic logic signed [31:0] rand_rate();
    case ($urandom_range(0, 7))
      0, 1: return $urandom;
      2: begin
        case ($urandom_range(0, 3))
          0: return 32'sh7fff_ffff;
          1: return 32'sh8000_0000;
          2: return 32'sh0;
          default: return -32'sd1;
        endcase
      end
      default: return int'($urandom_range(0, 32'h0040_0000)) - 32'sh0020_0000;
    endcase
  endfunction

  function automatic logic signed [THR_WIDTH-1:0] rand_throttle();
    logic [31:0] raw;
    int          thr;
    raw = $urandom;
    thr = int'($urandom_range(0, 32768)) - 16384;
    if ($urandom_range(0, 7) == 0) return raw[THR_WIDTH-1:0];
    return thr[THR_WIDTH-1:0];
  endfunction

  function automatic logic [31:0] rand_field(input int unsigned top);
    case ($urandom_range(0, 5))
      0: return 32'h0;
      1: return 32'h7fff_ffff;
      2: return $urandom & 32'h7fff_ffff;
      default: return $urandom_range(0, top);
    endcase
  endfunction

  function automatic logic [31:0] rand_step();
    case ($urandom_range(0, 4))
      0: return 32'd0;
      1: return 32'd65536;
      default: return $urandom_range(0, 65536);
    endcase
  endfunction

  // stimulus sequence
  initial begin : stimulus
    logic signed [31:0] rc;
    logic signed [31:0] rm;
    reg_shadow = '{default: 0};
    reg_shadow[REG_STEP] = u64_t'(STEP_TIME_RST);
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait_idle();

    // reset settings: zero gains and limits
    add_item(32'sh0001_0000, 32'sh0, 16'sd16384);
    add_item(32'sh7fff_ffff, 32'sh8000_0000, -16'sd16384);
    add_item(32'sh8000_0000, 32'sh7fff_ffff, 16'sh7fff);
    wait_idle();

    // moderate gains and limits
    write_all(32'd65536, 32'd32768, 32'd16384, 32'd655, 32'd655360,
              32'd6553600, 32'd13107200, 32'd9830400);
    add_item(32'sh0, 32'sh0, 16'sd0);
    add_item(32'sh7fff_ffff, 32'sh8000_0000, 16'sd16384);
    add_item(32'sh8000_0000, 32'sh7fff_ffff, -16'sd16384);
    add_item(32'sh7fff_ffff, 32'sh7fff_ffff, 16'sh7fff);
    add_item(32'sh8000_0000, 32'sh8000_0000, 16'sh8000);
    add_item(32'sh0001_0000, 32'sh0, 16'sd8192);
    add_item(32'sh0, 32'sh0001_0000, -16'sd8192);
    // integral runs into its clamp
    repeat (3) add_item(32'sh4000_0000, 32'sh0, 16'sd1);
    wait_idle();

    // every gain and limit at its top, full step
    write_all(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'd65536, 32'h7fff_ffff,
              32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
    add_item(32'sh7fff_ffff, 32'sh8000_0000, 16'sd16384);
    add_item(32'sh8000_0000, 32'sh7fff_ffff, -16'sd16384);
    add_item(32'sh1, 32'sh0, 16'sd1);
    add_item(32'sh0, 32'sh1, -16'sd1);
    add_item(32'sh7fff_ffff, 32'sh0, 16'sh7fff);
    add_item(32'sh8000_0000, 32'sh0, 16'sh8000);
    wait_idle();

    // zero step time stops the integral; zero limits
    write_all(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'd0, 32'h0,
              32'h0, 32'h0, 32'h0);
    add_item(32'sh0010_0000, 32'sh0, 16'sd16384);
    add_item(32'sh0, 32'sh0010_0000, -16'sd16384);
    wait_idle();
    write_reg(REG_INT_LIMIT, 32'h7fff_ffff);
    write_reg(REG_MAX_MZ, 32'h7fff_ffff);
    write_reg(REG_MAX_DRIVE, 32'd65536);
    add_item(32'sh0010_0000, 32'sh0, 16'sd16384);
    add_item(32'sh0, 32'sh0010_0000, -16'sd16384);
    wait_idle();

    // random settings, each with a run of random updates
    for (int ph = 0; ph < 6; ph++) begin
      no_idle = (ph == 2 || ph == 5);
      write_all(rand_field(32'h0004_0000), rand_field(32'h0004_0000),
                rand_field(32'h0004_0000), rand_step(), rand_field(32'h0400_0000),
                rand_field(32'h0400_0000), rand_field(32'h0400_0000),
                rand_field(32'h0400_0000));
      for (int n = 0; n < 150; n++) begin
        rc = rand_rate();
        if ($urandom_range(0, 3) == 0) rm = rand_rate();
        else rm = rc + (int'($urandom_range(0, 32'h0002_0000)) - 32'sh0001_0000);
        add_item(rc, rm, rand_throttle());
      end
      wait_idle();
    end

    // drain and finish
    repeat (40) @(posedge clk_i);
    if (error_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2000000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
